/* hw/rtl/iedb_pkg.sv */
package iedb_pkg;

  localparam int NUM_INPUTS_DEFAULT = 8;
  localparam int MAX_LANES = 8;
  localparam int TIME_W = 32;
  localparam int DEBOUNCE_W = 16;
  localparam int LONG_PRESS_W = 20;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [LONG_PRESS_W-1:0] LONG_PRESS_RESET = 20'd3000;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_PRELOAD = 2'd2;
  localparam logic [1:0] CMD_NOP = 2'd3;

  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_LONG_PRESS = 1'b1;

  // Decoded command, shared by every lane and the button timer.
  typedef struct packed {
    logic sample;
    logic tick;
    logic preload;
  } op_t;

endpackage

/* hw/rtl/iedb_lane.sv */
module iedb_lane
  import iedb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  op_t                   op,
  input  logic                  level,
  input  logic [TIME_W-1:0]     time_now,
  input  logic [TIME_W-1:0]     time_upd,
  input  logic [DEBOUNCE_W-1:0] debounce_ticks,
  output logic                  stored_next,
  output logic                  open_next,
  output logic                  latched_next
);

  logic              stored;
  logic              open;
  logic              latched;
  logic [TIME_W-1:0] stamp;
  logic [TIME_W-1:0] stamp_next;
  logic [TIME_W-1:0] elapsed;
  logic              open_cmd;

  always_comb begin
    stored_next = stored;
    open_cmd    = open;
    latched_next = latched;
    stamp_next  = stamp;
    if (op.sample && (level != stored)) begin
      stored_next = level;
      if (open) begin
        open_cmd = 1'b0;
      end else begin
        open_cmd     = 1'b1;
        stamp_next   = time_now;
        latched_next = ~level;
      end
    end else if (op.preload) begin
      stored_next  = level;
      latched_next = ~level;
      open_cmd     = 1'b0;
    end
    // Windows close once they have been open for the full debounce time.
    elapsed   = time_upd - stamp_next;
    open_next = open_cmd && (elapsed < {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ticks});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored  <= 1'b0;
      open    <= 1'b0;
      latched <= 1'b0;
    end else if (advance) begin
      stored  <= stored_next;
      open    <= open_next;
      latched <= latched_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stamp <= stamp_next;
    end
  end

endmodule

/* hw/rtl/iedb_button.sv */
module iedb_button
  import iedb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  op_t                     op,
  input  logic                    level,
  input  logic [TIME_W-1:0]       time_upd,
  input  logic [LONG_PRESS_W-1:0] long_press_ticks,
  output logic                    held_next,
  output logic                    long_press
);

  logic              button;
  logic              button_next;
  logic              timing;
  logic [TIME_W-1:0] stamp;
  logic [TIME_W-1:0] stamp_next;
  logic [TIME_W-1:0] elapsed;
  logic              reached;

  always_comb begin
    button_next = button;
    held_next   = timing;
    stamp_next  = stamp;
    long_press  = 1'b0;
    // A fresh press has zero elapsed time; otherwise measure from the stored stamp.
    elapsed = time_upd - stamp;
    if (op.sample && (level != button) && !level) begin
      elapsed = '0;
    end
    reached = (elapsed >= {{(TIME_W-LONG_PRESS_W){1'b0}}, long_press_ticks});
    if (op.sample && (level != button)) begin
      button_next = level;
      if (level) begin
        if (timing) begin
          held_next  = 1'b0;
          long_press = reached;
        end
      end else begin
        stamp_next = time_upd;
        held_next  = 1'b1;
      end
    end else if (op.preload) begin
      button_next = level;
      held_next   = 1'b0;
    end
    if (held_next && reached) begin
      held_next  = 1'b0;
      long_press = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button <= 1'b1;
      timing <= 1'b0;
    end else if (advance) begin
      button <= button_next;
      timing <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stamp <= stamp_next;
    end
  end

endmodule

/* hw/rtl/input_edge_debounce_long_press.sv */
// A word accepted at s_* goes through the input register, then the result register, before
// it is presented on m_*. Throughput: one word per cycle unless m_* stalls, which holds
// it in the input register; the result register frees up in the cycle it is taken.
// Reset (rst, synchronous, active high) clears levels, windows, latched copy, time and
// button timing, sets the button to released and restores the default thresholds.
module input_edge_debounce_long_press
  import iedb_pkg::*;
#(
  parameter int NUM_INPUTS = NUM_INPUTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] sampled_levels, [8] button_level, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] current_levels, [15:8] latched_active_low,
                                 // [23:16] window_open_mask, [24] button_held,
                                 // [25] long_press, rest zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int LANES = (NUM_INPUTS < MAX_LANES) ? NUM_INPUTS : MAX_LANES;

  logic                    in_valid;
  logic [1:0]              in_cmd;
  logic [MAX_LANES-1:0]    in_levels;
  logic                    in_button;
  logic                    advance;
  op_t                     op;
  logic [TIME_W-1:0]       time_now;
  logic [TIME_W-1:0]       time_upd;
  logic [DEBOUNCE_W-1:0]   debounce_ticks;
  logic [LONG_PRESS_W-1:0] long_press_ticks;
  logic [MAX_LANES-1:0]    levels_next;
  logic [MAX_LANES-1:0]    open_next;
  logic [MAX_LANES-1:0]    latched_next;
  logic                    held_next;
  logic                    long_press;

  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd    <= s_tuser;
      in_levels <= s_tdata[7:0];
      in_button <= s_tdata[8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_RESET;
      long_press_ticks <= LONG_PRESS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE:   debounce_ticks   <= cfg_data[DEBOUNCE_W-1:0];
        REG_LONG_PRESS: long_press_ticks <= cfg_data[LONG_PRESS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    op = '0;
    case (in_cmd)
      CMD_SAMPLE:  op.sample  = 1'b1;
      CMD_TICK:    op.tick    = 1'b1;
      CMD_PRELOAD: op.preload = 1'b1;
      CMD_NOP:     op = '0;
      default:     op = '0;
    endcase
  end

  assign time_upd = op.tick ? (time_now + 32'd1) : time_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now <= '0;
    end else if (advance) begin
      time_now <= time_upd;
    end
  end

  for (genvar i = 0; i < MAX_LANES; i++) begin : g_lane
    if (i < LANES) begin : g_used
      iedb_lane u_lane (
        .clk            (clk),
        .rst            (rst),
        .advance        (advance),
        .op             (op),
        .level          (in_levels[i]),
        .time_now       (time_now),
        .time_upd       (time_upd),
        .debounce_ticks (debounce_ticks),
        .stored_next    (levels_next[i]),
        .open_next      (open_next[i]),
        .latched_next   (latched_next[i])
      );
    end else begin : g_unused
      // Inputs beyond the configured count read as zero everywhere.
      assign levels_next[i]  = 1'b0;
      assign open_next[i]    = 1'b0;
      assign latched_next[i] = 1'b0;
    end
  end

  iedb_button u_button (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .op               (op),
    .level            (in_button),
    .time_upd         (time_upd),
    .long_press_ticks (long_press_ticks),
    .held_next        (held_next),
    .long_press       (long_press)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {6'd0, long_press, held_next, open_next, latched_next, levels_next};
    end
  end

endmodule

/* verif/tb_input_edge_debounce_long_press.sv */
module tb_input_edge_debounce_long_press;
  timeunit 1ns;
  timeprecision 1ps;

  import iedb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SINK_BLOCK_CYCLES = 300;
  localparam int unsigned NUM_PHASES = 7;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] levels;
    logic       button;
  } pin_word_t;

  // Packed from the top down so that it lines up with m_tdata[25:0].
  typedef struct packed {
    logic       long_press;
    logic       held;
    logic [7:0] win_open;
    logic [7:0] latched;
    logic [7:0] levels;
  } status_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  input_edge_debounce_long_press u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  pin_word_t   pending_pins[$];
  status_t     pending_status[$];
  logic        s_fire;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  logic        sink_block_req;
  int unsigned sink_block_left;
  logic [7:0]  gen_levels;
  logic        gen_button;

  // Mirror of the block's registers and state.
  logic [15:0] debounce_limit;
  logic [19:0] hold_limit;
  logic [7:0]  lvl_q;
  logic [7:0]  win_q;
  logic [7:0]  latch_q;
  logic [31:0] edge_at[8];
  logic [31:0] now_ms;
  logic [31:0] press_at;
  logic        timing_q;
  logic        button_q;

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic status_t advance_debouncer(input pin_word_t w);
    logic        flag;
    logic [7:0]  changed;
    logic [31:0] age;
    status_t     r;
    flag = 1'b0;
    case (w.cmd)
      CMD_SAMPLE: begin
        changed = w.levels ^ lvl_q;
        for (int i = 0; i < 8; i++) begin
          if (changed[i]) begin
            lvl_q[i] = w.levels[i];
            if (win_q[i]) begin
              // Another edge inside the open window is a bounce and cancels it.
              win_q[i] = 1'b0;
            end else begin
              win_q[i] = 1'b1;
              edge_at[i] = now_ms;
              latch_q[i] = ~w.levels[i];
            end
          end
        end
        if (w.button != button_q) begin
          button_q = w.button;
          if (w.button) begin
            if (timing_q) begin
              timing_q = 1'b0;
              age = now_ms - press_at;
              if (age >= 32'(hold_limit)) flag = 1'b1;
            end
          end else begin
            press_at = now_ms;
            timing_q = 1'b1;
          end
        end
      end
      CMD_TICK: now_ms = now_ms + 32'd1;
      CMD_PRELOAD: begin
        lvl_q = w.levels;
        latch_q = ~w.levels;
        win_q = 8'h00;
        button_q = w.button;
        timing_q = 1'b0;
      end
      default: ;
    endcase
    for (int i = 0; i < 8; i++) begin
      age = now_ms - edge_at[i];
      if (win_q[i] && age >= 32'(debounce_limit)) win_q[i] = 1'b0;
    end
    age = now_ms - press_at;
    if (timing_q && age >= 32'(hold_limit)) begin
      timing_q = 1'b0;
      flag = 1'b1;
    end
    r.levels = lvl_q;
    r.latched = latch_q;
    r.win_open = win_q;
    r.held = timing_q;
    r.long_press = flag;
    return r;
  endfunction

  function automatic pin_word_t next_random_word();
    pin_word_t   w;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) w.cmd = CMD_SAMPLE;
    else if (pick < 85) w.cmd = CMD_TICK;
    else if (pick < 92) w.cmd = CMD_PRELOAD;
    else w.cmd = CMD_NOP;
    // Mostly single-bit changes, so that bounces land inside open windows.
    case ($urandom_range(3))
      0: gen_levels = 8'($urandom);
      1, 2: gen_levels = gen_levels ^ (8'h01 << $urandom_range(7));
      default: ;
    endcase
    if ($urandom_range(5) == 0) gen_button = ~gen_button;
    w.levels = gen_levels;
    w.button = gen_button;
    return w;
  endfunction

  task automatic queue_word(input logic [1:0] cmd, input logic [7:0] levels,
                            input logic button);
    pin_word_t w;
    w.cmd = cmd;
    w.levels = levels;
    w.button = button;
    pending_pins.push_back(w);
  endtask

  task automatic wait_idle();
    while (pending_pins.size() != 0 || s_tvalid || pending_status.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_DEBOUNCE) debounce_limit = val[15:0];
    else hold_limit = val[19:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
  endtask

  // Input driver: holds a word until it is taken, then maybe pauses.
  always @(negedge clk) begin : drive_pins
    logic offer;
    if (!rst && (!s_tvalid || s_fire)) begin
      if (s_tvalid) void'(pending_pins.pop_front());
      offer = (pending_pins.size() != 0) && ($urandom_range(99) >= send_idle_pct);
      s_tvalid <= offer;
      if (offer) begin
        s_tdata <= {7'd0, pending_pins[0].button, pending_pins[0].levels};
        s_tuser <= pending_pins[0].cmd;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst)
      m_tready <= (sink_block_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
  always @(posedge clk) begin
    if (sink_block_req) begin
      sink_block_left <= SINK_BLOCK_CYCLES;
      sink_block_req = 1'b0;
    end else if (sink_block_left != 0) begin
      sink_block_left <= sink_block_left - 1;
    end
  end

  // Monitor: predicts on each accepted input word and checks each output word.
  always @(posedge clk) begin : watch_status
    status_t   want;
    pin_word_t w;
    if (!rst) begin
      s_fire <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        w.cmd = s_tuser;
        w.levels = s_tdata[7:0];
        w.button = s_tdata[8];
        pending_status.push_back(advance_debouncer(w));
      end
      if (m_tvalid && m_tready) begin
        if (pending_status.size() == 0) begin
          flag_mismatch("unexpected word", 32'd0, m_tdata);
        end else begin
          want = pending_status.pop_front();
          if (m_tdata[7:0] != want.levels)
            flag_mismatch("current_levels", 32'(want.levels), 32'(m_tdata[7:0]));
          if (m_tdata[15:8] != want.latched)
            flag_mismatch("latched_active_low", 32'(want.latched), 32'(m_tdata[15:8]));
          if (m_tdata[23:16] != want.win_open)
            flag_mismatch("window_open_mask", 32'(want.win_open), 32'(m_tdata[23:16]));
          if (m_tdata[24] != want.held)
            flag_mismatch("button_held", 32'(want.held), 32'(m_tdata[24]));
          if (m_tdata[25] != want.long_press)
            flag_mismatch("long_press", 32'(want.long_press), 32'(m_tdata[25]));
          if (m_tdata[31:26] != 6'd0)
            flag_mismatch("padding", 32'd0, 32'(m_tdata[31:26]));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL input_edge_debounce_long_press");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned deb_tab[NUM_PHASES] = '{1, 4, 65535, 0, 7, 2, 50};
    int unsigned hold_tab[NUM_PHASES] = '{1, 12, 1000000, 0, 25, 6, 3000};
    int unsigned sidle_tab[NUM_PHASES] = '{0, 76, 0, 30, 30, 0, 76};
    int unsigned rstall_tab[NUM_PHASES] = '{0, 0, 76, 30, 30, 0, 76};
    int unsigned count_tab[NUM_PHASES] = '{300, 300, 250, 250, 300, 200, 275};

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_NOP;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_DEBOUNCE;
    cfg_data = '0;
    s_fire = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    cycle_count = 0;
    sink_block_req = 1'b0;
    sink_block_left = 0;
    gen_levels = 8'h00;
    gen_button = 1'b1;
    debounce_limit = DEBOUNCE_RESET;
    hold_limit = LONG_PRESS_RESET;
    lvl_q = 8'h00;
    win_q = 8'h00;
    latch_q = 8'h00;
    for (int i = 0; i < 8; i++) edge_at[i] = 32'd0;
    now_ms = 32'd0;
    press_at = 32'd0;
    timing_q = 1'b0;
    button_q = 1'b1;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default thresholds: preloads, bounces, ignored fields, short press.
    queue_word(CMD_PRELOAD, 8'hFF, 1'b1);
    queue_word(CMD_PRELOAD, 8'h00, 1'b0);
    queue_word(CMD_SAMPLE, 8'h00, 1'b1);   // release with no press being timed
    queue_word(CMD_SAMPLE, 8'hFF, 1'b1);
    queue_word(CMD_SAMPLE, 8'h0F, 1'b1);   // upper bits bounce back
    queue_word(CMD_SAMPLE, 8'hF0, 1'b1);
    queue_word(CMD_NOP, 8'hAA, 1'b0);
    queue_word(CMD_TICK, 8'h55, 1'b0);
    queue_word(CMD_SAMPLE, 8'hAA, 1'b0);
    queue_word(CMD_SAMPLE, 8'h55, 1'b1);
    wait_idle();

    // Zero thresholds: windows close and a press is flagged on the same word.
    write_reg(REG_DEBOUNCE, 32'd0);
    write_reg(REG_LONG_PRESS, 32'd0);
    queue_word(CMD_SAMPLE, 8'h01, 1'b0);
    queue_word(CMD_SAMPLE, 8'h00, 1'b1);
    wait_idle();

    // Threshold lowered mid-press, so the release itself flags.
    write_reg(REG_DEBOUNCE, 32'd3);
    write_reg(REG_LONG_PRESS, 32'd100);
    queue_word(CMD_SAMPLE, 8'h80, 1'b0);
    queue_word(CMD_TICK, 8'h00, 1'b1);
    queue_word(CMD_TICK, 8'h00, 1'b1);
    queue_word(CMD_TICK, 8'h00, 1'b1);
    wait_idle();
    write_reg(REG_LONG_PRESS, 32'd2);
    queue_word(CMD_SAMPLE, 8'h80, 1'b1);
    // Held past the threshold, then a release that flags nothing.
    queue_word(CMD_SAMPLE, 8'h00, 1'b0);
    queue_word(CMD_TICK, 8'h00, 1'b0);
    queue_word(CMD_TICK, 8'h00, 1'b0);
    queue_word(CMD_SAMPLE, 8'h00, 1'b1);
    // A preload stops a press being timed.
    queue_word(CMD_SAMPLE, 8'h00, 1'b0);
    queue_word(CMD_PRELOAD, 8'h3C, 1'b0);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_DEBOUNCE, deb_tab[p]);
      write_reg(REG_LONG_PRESS, hold_tab[p]);
      send_idle_pct = sidle_tab[p];
      recv_stall_pct = rstall_tab[p];
      for (int n = 0; n < count_tab[p]; n++) pending_pins.push_back(next_random_word());
      if (p == 5) sink_block_req = 1'b1;
      wait_idle();
    end

    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && pending_status.size() == 0) begin
      $display("PASS input_edge_debounce_long_press");
    end else begin
      $display("FAIL input_edge_debounce_long_press");
    end
    $finish;
  end

endmodule
